// File: rtl/smf_pkg.sv
`default_nettype none

package smf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 5;
  localparam int COUNT_W  = 5;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 5'd5;

  typedef struct packed {
    logic up;
    logic down;
    logic del_below;
  } smf_link_t;

endpackage

`default_nettype wire

// File: rtl/smf_cell.sv
`default_nettype none

module smf_cell #(
  parameter int IDX = 0,
  parameter int AW  = 4,
  parameter int CW  = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear,
  input  logic                                accept,
  input  logic                                full,
  input  logic [AW-1:0]                       oldest_age,
  input  logic [CW-1:0]                       new_fill,
  input  logic [CW-1:0]                       lo_idx,
  input  logic [CW-1:0]                       hi_idx,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] in_x,
  input  smf_pkg::smf_link_t                  lower_link,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] lower_val,
  input  logic [AW-1:0]                       lower_age,
  input  smf_pkg::smf_link_t                  upper_link,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] upper_val,
  input  logic [AW-1:0]                       upper_age,
  output smf_pkg::smf_link_t                  link,
  output logic signed [smf_pkg::SAMPLE_W-1:0] val,
  output logic [AW-1:0]                       age,
  output logic                                valid,
  output logic [smf_pkg::SAMPLE_W-1:0]        pick_lo,
  output logic [smf_pkg::SAMPLE_W-1:0]        pick_hi
);
  import smf_pkg::*;

  logic signed [SAMPLE_W-1:0] val_r, val_nxt;
  logic [AW-1:0]              age_r, age_nxt;
  logic                       valid_r, valid_nxt;
  logic                       del, kept, gt;

  always_comb begin
    del  = full && valid_r && (age_r == oldest_age);
    kept = valid_r && !del;
    gt   = valid_r && (val_r > in_x);
    link.del_below = lower_link.del_below || del;
    link.up        = kept && gt && !lower_link.del_below;
    link.down      = kept && !gt && lower_link.del_below;
  end

  always_comb begin
    val_nxt   = val_r;
    age_nxt   = age_r;
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (accept) begin
      valid_nxt = (CW'(IDX) < new_fill);
      if (kept && (gt == lower_link.del_below)) begin
        age_nxt = age_r + 1'b1;
      end else if (lower_link.up) begin
        val_nxt = lower_val;
        age_nxt = lower_age + 1'b1;
      end else if (upper_link.down) begin
        val_nxt = upper_val;
        age_nxt = upper_age + 1'b1;
      end else begin
        val_nxt = in_x;
        age_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

  assign val     = val_r;
  assign age     = age_r;
  assign valid   = valid_r;
  assign pick_lo = (lo_idx == CW'(IDX)) ? val_r : '0;
  assign pick_hi = (hi_idx == CW'(IDX)) ? val_r : '0;

endmodule

`default_nettype wire

// File: rtl/sliding_median_filter_top.sv
// Running median over the last window_size samples, kept as a sorted row of cells.
// Throughput: one sample per cycle unless out_stall holds a pending result; each
// cell drops, keeps or shifts by one per sample. The median is read from the
// cell row into the output register after the sorted insert, unless stalled.
// Reset (synchronous, active low) empties the window and sets window_size to 5;
// a configuration write also empties the window.
`default_nettype none

module sliding_median_filter_top #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [smf_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smf_pkg::SAMPLE_W-1:0] out_median,
  output logic [smf_pkg::COUNT_W-1:0]         out_held_count
);
  import smf_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic [CFG_W-1:0]           ws_r, ws_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic                       pending_r, pending_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_median_r, out_median_nxt;
  logic [COUNT_W-1:0]         out_count_r, out_count_nxt;

  logic [CW-1:0]              n_c, new_fill, lo_idx, hi_idx;
  logic [AW-1:0]              oldest_age;
  logic                       full, accept, load_out;

  smf_link_t                  link   [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] val    [WINDOW_MAX];
  logic [AW-1:0]              age    [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      valid;
  logic [SAMPLE_W-1:0]        pick_lo [WINDOW_MAX];
  logic [SAMPLE_W-1:0]        pick_hi [WINDOW_MAX];
  logic [SAMPLE_W-1:0]        lo_val, hi_val;
  logic [SAMPLE_W:0]          mid_sum;

  always_comb begin
    if (ws_r == '0) begin
      n_c = CW'(1);
    end else if (int'(ws_r) > WINDOW_MAX) begin
      n_c = CW'(WINDOW_MAX);
    end else begin
      n_c = CW'(ws_r);
    end
  end

  assign full       = (fill_r == n_c);
  assign new_fill   = full ? fill_r : fill_r + 1'b1;
  assign oldest_age = AW'(n_c - 1'b1);
  assign lo_idx     = (fill_r - 1'b1) >> 1;
  assign hi_idx     = fill_r >> 1;

  assign load_out = pending_r && (!out_valid_r || !out_stall);
  assign in_stall = pending_r && !load_out;
  assign accept   = in_valid && !in_stall;

  genvar g;
  generate
    for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
      smf_link_t                  lo_link, hi_link;
      logic signed [SAMPLE_W-1:0] lo_v, hi_v;
      logic [AW-1:0]              lo_a, hi_a;
      if (g == 0) begin : g_first
        assign lo_link = '0;
        assign lo_v    = '0;
        assign lo_a    = '0;
      end else begin : g_mid_lo
        assign lo_link = link[g-1];
        assign lo_v    = val[g-1];
        assign lo_a    = age[g-1];
      end
      if (g == WINDOW_MAX - 1) begin : g_last
        assign hi_link = '0;
        assign hi_v    = '0;
        assign hi_a    = '0;
      end else begin : g_mid_hi
        assign hi_link = link[g+1];
        assign hi_v    = val[g+1];
        assign hi_a    = age[g+1];
      end
      smf_cell #(
        .IDX (g),
        .AW  (AW),
        .CW  (CW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cfg_wr_en),
        .accept     (accept),
        .full       (full),
        .oldest_age (oldest_age),
        .new_fill   (new_fill),
        .lo_idx     (lo_idx),
        .hi_idx     (hi_idx),
        .in_x       (in_sample),
        .lower_link (lo_link),
        .lower_val  (lo_v),
        .lower_age  (lo_a),
        .upper_link (hi_link),
        .upper_val  (hi_v),
        .upper_age  (hi_a),
        .link       (link[g]),
        .val        (val[g]),
        .age        (age[g]),
        .valid      (valid[g]),
        .pick_lo    (pick_lo[g]),
        .pick_hi    (pick_hi[g])
      );
    end
  endgenerate

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      lo_val = lo_val | pick_lo[i];
      hi_val = hi_val | pick_hi[i];
    end
    mid_sum = {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
  end

  always_comb begin
    ws_nxt         = cfg_wr_en ? cfg_wr_data : ws_r;
    fill_nxt       = fill_r;
    pending_nxt    = pending_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    out_count_nxt  = out_count_r;
    if (cfg_wr_en) begin
      fill_nxt = '0;
    end else if (accept) begin
      fill_nxt = new_fill;
    end
    if (accept) begin
      pending_nxt = 1'b1;
    end else if (load_out) begin
      pending_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_median_nxt = mid_sum[SAMPLE_W:1];
      out_count_nxt  = COUNT_W'(fill_r);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= WINDOW_SIZE_RESET;
      fill_r      <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_median_r <= out_median_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_median     = out_median_r;
  assign out_held_count = out_count_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_c)
    else $error("fill count exceeds window");

  a_valid_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid) == int'(fill_r))
    else $error("occupied cells disagree with fill count");

  a_full_holds_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept && full && !cfg_wr_en |=> fill_r == $past(fill_r))
    else $error("fill count moved while window full");

  a_result_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pending_r))
    else $error("result presented without a pending transaction");

endmodule

`default_nettype wire
